// ===== rtl/drum_pad_midi_trigger_assert.svh =====
// Assertion macros shared by the drum pad trigger RTL.
`ifndef DRUM_PAD_MIDI_TRIGGER_ASSERT_SVH
`define DRUM_PAD_MIDI_TRIGGER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DPMT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DPMT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/dpmt_pkg.sv =====
// Shared types, codes and constants for the drum pad trigger.
`default_nettype none

package dpmt_pkg;

    // Default ADC resolution
    localparam int ADC_BITS_DEF = 12;

    // Field and register widths
    localparam int THR_W      = 12;
    localparam int VEL_W      = 7;
    localparam int VEL_RAW_W  = 8;
    localparam int NOTE_W     = 7;
    localparam int HOLD_W     = 8;
    localparam int CH_W       = 4;
    localparam int STATUS_W   = 8;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_BUTTON = 2'd1,
        ACT_TICK   = 2'd2
    } action_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAT_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYM_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_FLOOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_CEIL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_HOLD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OTHER_HOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL    = 3'd7;

    // Register reset values
    localparam logic [THR_W-1:0]  RST_KICK_THR   = 12'd497;
    localparam logic [THR_W-1:0]  RST_HAT_THR    = 12'd249;
    localparam logic [THR_W-1:0]  RST_CYM_THR    = 12'd125;
    localparam logic [VEL_W-1:0]  RST_VEL_FLOOR  = 7'd30;
    localparam logic [VEL_W-1:0]  RST_VEL_CEIL   = 7'd115;
    localparam logic [HOLD_W-1:0] RST_KICK_HOLD  = 8'd150;
    localparam logic [HOLD_W-1:0] RST_OTHER_HOLD = 8'd50;
    localparam logic [CH_W-1:0]   RST_CHANNEL    = 4'd0;

    // MIDI status nibbles and note numbers
    localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [NOTE_W-1:0]   NOTE_KICK       = 7'd36;
    localparam logic [NOTE_W-1:0]   NOTE_CYMBAL     = 7'd38;
    localparam logic [NOTE_W-1:0]   NOTE_HAT_CLOSED = 7'd60;
    localparam logic [NOTE_W-1:0]   NOTE_HAT_OPEN   = 7'd64;

    // Configuration register set
    typedef struct packed {
        logic [THR_W-1:0]  kick_threshold;
        logic [THR_W-1:0]  hat_threshold;
        logic [THR_W-1:0]  cymbal_threshold;
        logic [VEL_W-1:0]  velocity_floor;
        logic [VEL_W-1:0]  velocity_ceiling;
        logic [HOLD_W-1:0] kick_holdoff_ms;
        logic [HOLD_W-1:0] other_holdoff_ms;
        logic [CH_W-1:0]   midi_channel;
    } cfg_t;

    // One hit handed from the trigger stage to the result stage
    typedef struct packed {
        logic              load;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } hit_t;

endpackage

`default_nettype wire

// ===== rtl/dpmt_cfg_regs.sv =====
// Configuration register file for the drum pad trigger.
`default_nettype none

module dpmt_cfg_regs
    import dpmt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Write decode, each value cut to its register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KICK_THR:   cfg_next.kick_threshold   = cfg_data[THR_W-1:0];
                CFG_HAT_THR:    cfg_next.hat_threshold    = cfg_data[THR_W-1:0];
                CFG_CYM_THR:    cfg_next.cymbal_threshold = cfg_data[THR_W-1:0];
                CFG_VEL_FLOOR:  cfg_next.velocity_floor   = cfg_data[VEL_W-1:0];
                CFG_VEL_CEIL:   cfg_next.velocity_ceiling = cfg_data[VEL_W-1:0];
                CFG_KICK_HOLD:  cfg_next.kick_holdoff_ms  = cfg_data[HOLD_W-1:0];
                CFG_OTHER_HOLD: cfg_next.other_holdoff_ms = cfg_data[HOLD_W-1:0];
                CFG_CHANNEL:    cfg_next.midi_channel     = cfg_data[CH_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kick_threshold   <= RST_KICK_THR;
            cfg_reg.hat_threshold    <= RST_HAT_THR;
            cfg_reg.cymbal_threshold <= RST_CYM_THR;
            cfg_reg.velocity_floor   <= RST_VEL_FLOOR;
            cfg_reg.velocity_ceiling <= RST_VEL_CEIL;
            cfg_reg.kick_holdoff_ms  <= RST_KICK_HOLD;
            cfg_reg.other_holdoff_ms <= RST_OTHER_HOLD;
            cfg_reg.midi_channel     <= RST_CHANNEL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/dpmt_trigger.sv =====
// Input register, pad state and hit evaluation for the drum pad trigger.
`default_nettype none

module dpmt_trigger
    import dpmt_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [ADC_BITS-1:0] kick_sample,
    input  wire logic [ADC_BITS-1:0] hat_sample,
    input  wire logic [ADC_BITS-1:0] cymbal_sample,
    input  cfg_t                     cfg,
    input  wire logic                pair_free,
    output hit_t                     hit
);

    // Velocity scaling: floor(sample * 127 / VEL_DIV) by a reciprocal multiply.
    // SHIFT is large enough that the rounded-up reciprocal is exact over the
    // whole range of sample * 127.
    localparam int P_W = ADC_BITS + 7;
    localparam longint unsigned VEL_DIV =
        ((64'd1 << ADC_BITS) - 64'd1) * 64'd2 / 64'd3;
    localparam int DIV_W = $clog2(VEL_DIV + 64'd1);
    localparam int SHIFT = P_W + DIV_W;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + VEL_DIV - 64'd1) / VEL_DIV;
    localparam int RECIP_W = $clog2(RECIP + 64'd1);
    localparam int PROD_W = P_W + RECIP_W;
    localparam int CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

    // Input register
    logic                valid_reg;
    logic                valid_next;
    action_t             action_reg;
    logic [ADC_BITS-1:0] kick_reg;
    logic [ADC_BITS-1:0] hat_reg;
    logic [ADC_BITS-1:0] cymbal_reg;

    // Pad state
    logic              hat_open_reg;
    logic              hat_open_next;
    logic [HOLD_W-1:0] holdoff_reg;
    logic [HOLD_W-1:0] holdoff_next;

    logic                 in_take;
    logic                 advance;
    logic                 sample_ok;
    logic                 kick_hit;
    logic                 hat_hit;
    logic                 cym_hit;
    logic                 any_hit;
    logic [ADC_BITS-1:0]  sel_sample;
    logic [NOTE_W-1:0]    sel_note;
    logic [HOLD_W-1:0]    sel_hold;
    logic [P_W-1:0]       scaled;
    logic [PROD_W-1:0]    product;
    logic [VEL_RAW_W-1:0] vel_raw;
    logic [VEL_W-1:0]     vel_clamped;

    // Threshold checks in priority order
    assign sample_ok = (action_reg == ACT_SAMPLE) && (holdoff_reg == '0);
    assign kick_hit  = CMP_W'(kick_reg)   >= CMP_W'(cfg.kick_threshold);
    assign hat_hit   = CMP_W'(hat_reg)    >= CMP_W'(cfg.hat_threshold);
    assign cym_hit   = CMP_W'(cymbal_reg) >= CMP_W'(cfg.cymbal_threshold);
    assign any_hit   = sample_ok && (kick_hit || hat_hit || cym_hit);

    always_comb
    begin
        if (kick_hit)
        begin
            sel_sample = kick_reg;
            sel_note   = NOTE_KICK;
            sel_hold   = cfg.kick_holdoff_ms;
        end
        else if (hat_hit)
        begin
            sel_sample = hat_reg;
            sel_note   = hat_open_reg ? NOTE_HAT_OPEN : NOTE_HAT_CLOSED;
            sel_hold   = cfg.other_holdoff_ms;
        end
        else
        begin
            sel_sample = cymbal_reg;
            sel_note   = NOTE_CYMBAL;
            sel_hold   = cfg.other_holdoff_ms;
        end
    end

    // Velocity: times 127 by shift and subtract, then the reciprocal multiply
    assign scaled  = (P_W'(sel_sample) << 7) - P_W'(sel_sample);
    assign product = PROD_W'(scaled) * PROD_W'(RECIP);
    assign vel_raw = product[SHIFT +: VEL_RAW_W];

    // Floor is tested first, then ceiling
    always_comb
    begin
        if (vel_raw < VEL_RAW_W'(cfg.velocity_floor))
            vel_clamped = cfg.velocity_floor;
        else if (vel_raw > VEL_RAW_W'(cfg.velocity_ceiling))
            vel_clamped = cfg.velocity_ceiling;
        else
            vel_clamped = vel_raw[VEL_W-1:0];
    end

    // Items with no results leave at once; a hit waits for the result stage
    assign advance  = valid_reg && (!any_hit || pair_free);
    assign in_stall = valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign hit.load     = advance && any_hit;
    assign hit.note     = sel_note;
    assign hit.velocity = vel_clamped;

    // State update when the registered item leaves
    always_comb
    begin
        hat_open_next = hat_open_reg;
        holdoff_next  = holdoff_reg;
        if (advance)
        begin
            unique case (action_reg)
                ACT_BUTTON:
                    hat_open_next = ~hat_open_reg;
                ACT_TICK:
                    if (holdoff_reg != '0)
                        holdoff_next = holdoff_reg - HOLD_W'(1);
                ACT_SAMPLE:
                    if (any_hit)
                        holdoff_next = sel_hold;
                default:
                    holdoff_next = holdoff_reg;
            endcase
        end
    end

    always_comb
    begin
        if (in_take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            hat_open_reg <= 1'b0;
            holdoff_reg  <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            hat_open_reg <= hat_open_next;
            holdoff_reg  <= holdoff_next;
        end
    end

    // Request payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= action_t'(action);
            kick_reg   <= kick_sample;
            hat_reg    <= hat_sample;
            cymbal_reg <= cymbal_sample;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dpmt_result.sv =====
// Result register sending the note-on / note-off pair of a hit.
`default_nettype none

module dpmt_result
    import dpmt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  hit_t                      hit,
    input  wire logic [CH_W-1:0]      midi_channel,
    output logic                      pair_free,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [STATUS_W-1:0]       status_byte,
    output logic [NOTE_W-1:0]         note_number,
    output logic [VEL_W-1:0]          velocity,
    output logic                      last_of_hit
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ON   = 3'b010,
        PH_OFF  = 3'b100
    } phase_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [NOTE_W-1:0] note_reg;
    logic [VEL_W-1:0]  vel_reg;
    logic              out_take;

    assign out_take  = out_valid && !out_stall;
    assign pair_free = (phase_reg == PH_IDLE) || ((phase_reg == PH_OFF) && !out_stall);

    // Pair sequencer
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
                if (hit.load)
                    phase_next = PH_ON;
            PH_ON:
                if (out_take)
                    phase_next = PH_OFF;
            PH_OFF:
                if (out_take)
                    phase_next = hit.load ? PH_ON : PH_IDLE;
            default:
                phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    // Hit payload
    always_ff @(posedge clk)
    begin
        if (hit.load)
        begin
            note_reg <= hit.note;
            vel_reg  <= hit.velocity;
        end
    end

    // Output fields
    assign out_valid   = (phase_reg == PH_ON) || (phase_reg == PH_OFF);
    assign last_of_hit = (phase_reg == PH_OFF);
    assign note_number = note_reg;
    assign velocity    = last_of_hit ? '0 : vel_reg;
    assign status_byte = (last_of_hit ? STATUS_NOTE_OFF : STATUS_NOTE_ON)
                         | STATUS_W'(midi_channel);

endmodule

`default_nettype wire

// ===== rtl/drum_pad_midi_trigger.sv =====
// A hit waits in the input register until the result register is free; the
// note-on is valid once it loads there, the note-off from the edge that takes
// the note-on. Throughput: one request per cycle for ticks, button presses and
// quiet sample sets while no hit waits; a hit holds the result register for its
// two results. Reset: registers to defaults, hat closed, holdoff zero.
`default_nettype none

`include "drum_pad_midi_trigger_assert.svh"

module drum_pad_midi_trigger
    import dpmt_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ACTION_W-1:0]   action,
    input  wire logic [ADC_BITS-1:0]   kick_sample,
    input  wire logic [ADC_BITS-1:0]   hat_sample,
    input  wire logic [ADC_BITS-1:0]   cymbal_sample,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STATUS_W-1:0]        status_byte,
    output logic [NOTE_W-1:0]          note_number,
    output logic [VEL_W-1:0]           velocity,
    output logic                       last_of_hit
);

    cfg_t cfg;
    hit_t hit;
    logic pair_free;

    dpmt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dpmt_trigger #(
        .ADC_BITS (ADC_BITS)
    ) u_trigger (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .kick_sample   (kick_sample),
        .hat_sample    (hat_sample),
        .cymbal_sample (cymbal_sample),
        .cfg           (cfg),
        .pair_free     (pair_free),
        .hit           (hit)
    );

    dpmt_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .hit          (hit),
        .midi_channel (cfg.midi_channel),
        .pair_free    (pair_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status_byte  (status_byte),
        .note_number  (note_number),
        .velocity     (velocity),
        .last_of_hit  (last_of_hit)
    );

    // A taken note-on is always followed by its note-off on the same note
    `DPMT_ASSERT_NEXT(a_off_follows_on, out_valid && !out_stall && !last_of_hit,
        out_valid && last_of_hit)
    `DPMT_ASSERT_NEXT(a_pair_same_note, out_valid && !out_stall && !last_of_hit,
        note_number == $past(note_number))
    // Input side only backs up while a pair is waiting at the output
    `DPMT_ASSERT_NOW(a_stall_needs_pair, in_stall, out_valid)

endmodule

`default_nettype wire
